// File: rtl/pps_pkg.sv
// shared constants, widths and tables of the pure pursuit steering block
package pps_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int STALE_TICKS = 12;
  localparam int AGE_W       = 5;
  localparam logic [AGE_W-1:0] AGE_SAT = '1;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ST_AW  = $clog2(2 * MAX_POINTS);
  localparam int ST_DEPTH = 2 * MAX_POINTS;
  localparam int PT_W   = 48;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_WHEEL_BASE  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_STEER_LIMIT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SIDE_RATIO  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_REACH_MIN   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_REACH_MAX   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_REACH_GAIN  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SPEED_FLOOR = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SPEED_CAP   = 3'd7;

  // item kinds
  localparam logic [1:0] KIND_SPEED = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // cordic widths
  localparam int CRD_ITERS = 16;
  localparam int CRD_IW    = $clog2(CRD_ITERS);
  localparam int CRD_XW    = 36;
  localparam int CRD_ZW    = 19;

  // divider widths
  localparam int DIV_NW = 31;
  localparam int DIV_DW = 17;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  // arctangent table, rad * 65536
  function automatic logic signed [CRD_ZW-1:0] arc_tab(input logic [CRD_IW-1:0] i);
    logic signed [CRD_ZW-1:0] r;
    unique case (i)
      4'd0:  r = 19'sd51472;
      4'd1:  r = 19'sd30386;
      4'd2:  r = 19'sd16055;
      4'd3:  r = 19'sd8150;
      4'd4:  r = 19'sd4091;
      4'd5:  r = 19'sd2047;
      4'd6:  r = 19'sd1024;
      4'd7:  r = 19'sd512;
      4'd8:  r = 19'sd256;
      4'd9:  r = 19'sd128;
      4'd10: r = 19'sd64;
      4'd11: r = 19'sd32;
      4'd12: r = 19'sd16;
      4'd13: r = 19'sd8;
      4'd14: r = 19'sd4;
      default: r = 19'sd2;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/pps_store.sv
// double-banked path point memory, one write and one registered read port
module pps_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic [pps_pkg::ST_AW-1:0]    waddr,
  input  logic [pps_pkg::PT_W-1:0]     wdata,
  input  logic                         re,
  input  logic [pps_pkg::ST_AW-1:0]    raddr,
  output logic [pps_pkg::PT_W-1:0]     rdata
);
  import pps_pkg::*;

  logic [PT_W-1:0] mem [ST_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/pps_cordic.sv
// iterative cordic vectoring unit, one rotation per cycle
module pps_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [29:0] num,
  input  logic [31:0]        den,
  output logic               done,
  output logic signed [15:0] angle
);
  import pps_pkg::*;

  logic signed [CRD_XW-1:0] x, y;
  logic signed [CRD_ZW-1:0] z;
  logic [CRD_IW-1:0]        iter;
  logic                     busy;
  logic signed [CRD_XW-1:0] dx, dy;
  logic signed [CRD_ZW-1:0] zr;

  assign dx = y >>> iter;
  assign dy = x >>> iter;
  assign zr = z + CRD_ZW'(4);
  assign angle = 16'(zr >>> 3);

  // rotation step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= busy && !start && (iter == CRD_IW'(CRD_ITERS - 1));
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        x <= $signed({{(CRD_XW-32){1'b0}}, den});
        y <= CRD_XW'(num);
        z <= '0;
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + arc_tab(iter);
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - arc_tab(iter);
        end
        iter <= iter + 1'b1;
        if (iter == CRD_IW'(CRD_ITERS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

// File: rtl/pps_divu.sv
// restoring unsigned divider, one quotient bit per cycle
module pps_divu (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pps_pkg::DIV_NW-1:0]  dividend,
  input  logic [pps_pkg::DIV_DW-1:0]  divisor,
  output logic                        done,
  output logic [pps_pkg::DIV_NW-1:0]  quotient
);
  import pps_pkg::*;

  logic [DIV_DW:0]   rem;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_CW-1:0] cnt;
  logic              busy;

  assign trial = {rem[DIV_DW-1:0], quotient[DIV_NW-1]};

  // shift and subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == DIV_CW'(DIV_NW - 1));
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem      <= trial - {1'b0, dsr};
          quotient <= {quotient[DIV_NW-2:0], 1'b1};
        end else begin
          rem      <= trial;
          quotient <= {quotient[DIV_NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

// File: rtl/pure_pursuit_steering.sv
// top level of the pure pursuit steering controller
//
// channel  dir  handshake          payload
// s_axis   in   tvalid/tready      tdata speed/points, tuser kind, tlast point_last
// m_axis   out  tvalid/tready      tdata drive/steer/aim, tuser path_stale
// cfg      in   cfg_we             cfg_index, cfg_data
//
// speed updates and path points are stored while IDLE, so the next item can follow at once
// a tick runs the per-point read and multiply sequence until the scan stops, then
// the 16-step cordic and the 31-step divider where they are needed
// a stale tick goes from AGE straight to OUT; a stalled output holds the tick in OUT
// rst is synchronous; the point memory is not cleared, only written entries are read
// a waiting result holds m_tdata; the next item is taken meanwhile
module pure_pursuit_steering (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,  // speed_in, point_x, point_y, point_speed
  input  logic [1:0]                  s_tuser,  // kind
  input  logic                        s_tlast,  // point_last
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata,  // drive_speed, steer_angle, aim_x, aim_y, pad
  output logic                        m_tuser,  // path_stale
  input  logic                        cfg_we,
  input  logic [pps_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [pps_pkg::CFG_DW-1:0]  cfg_data
);
  import pps_pkg::*;

  typedef enum logic [4:0] {
    IDLE, AGE, LA, LB, LC, LD, RD, SQ, MUL, CMP, PICK, FETCH, PREP, CORD,
    CLAMP, CORN, DIV, FILT, FIN, OUT
  } state_t;

  state_t state;

  // configuration
  logic [11:0] wheel_base;
  logic [13:0] steer_limit;
  logic [15:0] side_ratio, reach_gain;
  logic [14:0] reach_min, reach_max, speed_floor, speed_cap;

  // persistent state
  logic             live_bank;
  logic [CNT_W-1:0] live_count, fill_count;
  logic [AGE_W-1:0] age_cnt;
  logic signed [15:0] filt, own_speed;

  // tick work registers
  logic [32:0] gprod;
  logic [14:0] la;
  logic [30:0] bprod;
  logic [29:0] a2, b2;
  logic [59:0] lim2;
  logic [CNT_W-1:0] i, idx;
  logic [30:0] x2, y2;
  logic [60:0] p1, p2;
  logic signed [15:0] ax, ay, pv, steer;
  logic [15:0] vm;
  logic        neg;
  logic [DIV_NW-1:0] dvd;
  logic [DIV_DW-1:0] dvs;
  logic [35:0] rprod;
  logic        tneg;

  // result registers
  logic signed [15:0] r_drive, r_aimx, r_aimy;
  logic signed [14:0] r_steer;
  logic               r_stale;

  // memory ports
  logic             st_we, st_re;
  logic [ST_AW-1:0] st_waddr, st_raddr;
  logic [PT_W-1:0]  st_rdata;

  // arithmetic units
  logic               crd_start, crd_done;
  logic signed [29:0] crd_num;
  logic [31:0]        crd_den;
  logic signed [15:0] crd_angle;
  logic               div_start, div_done;
  logic [DIV_NW-1:0]  div_q;

  logic s_acc;
  assign s_acc    = s_tvalid && s_tready;
  assign s_tready = (state == IDLE);

  // point write into the inactive bank
  assign st_we    = s_acc && (s_tuser == KIND_POINT) && (fill_count < CNT_W'(MAX_POINTS));
  assign st_waddr = ST_AW'(fill_count) + (live_bank ? '0 : ST_AW'(MAX_POINTS));

  // scan and fetch read address in the live bank
  logic [CNT_W-1:0] rd_idx, pick_idx;
  assign pick_idx = (idx == '0 && live_count > CNT_W'(1)) ? live_count - 1'b1 : idx;
  assign rd_idx   = (state == PICK) ? pick_idx : i;
  assign st_re    = (state == RD) || (state == PICK);
  assign st_raddr = ST_AW'(rd_idx) + (live_bank ? ST_AW'(MAX_POINTS) : '0);

  pps_store u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(s_tdata[63:16]),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  pps_cordic u_cordic (
    .clk(clk), .rst(rst), .start(crd_start), .num(crd_num), .den(crd_den),
    .done(crd_done), .angle(crd_angle)
  );

  pps_divu u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dvd), .divisor(dvs),
    .done(div_done), .quotient(div_q)
  );

  // combinational helpers
  logic [AGE_W-1:0]   age_n;
  logic               stale_n;
  logic [16:0]        spd;
  logic [21:0]        lsum;
  logic [14:0]        l_c1;
  logic [14:0]        bval;
  logic signed [15:0] rx, ry, rv, scap;
  logic signed [31:0] sqx, sqy;
  logic [31:0]        dsum;
  logic signed [15:0] lim, as16;
  logic signed [17:0] tsum;
  logic [17:0]        tn;
  logic [14:0]        tm;
  logic [61:0]        psum;

  always_comb begin
    age_n   = (age_cnt < AGE_SAT) ? age_cnt + 1'b1 : age_cnt;
    stale_n = (age_n > AGE_W'(STALE_TICKS)) || (age_n == AGE_SAT) || (live_count == '0);
    spd     = own_speed[15] ? 17'(-$signed({own_speed[15], own_speed}))
                            : {1'b0, own_speed};
    lsum    = {7'd0, reach_min} + 22'(gprod >> 12);
    l_c1    = (lsum > {7'd0, reach_max}) ? reach_max : lsum[14:0];
    bval    = (bprod[30:16] < 15'd100) ? 15'd100 : bprod[30:16];
    rx      = $signed(st_rdata[15:0]);
    ry      = $signed(st_rdata[31:16]);
    rv      = $signed(st_rdata[47:32]);
    scap    = $signed({1'b0, speed_cap});
    sqx     = rx * rx;
    sqy     = ry * ry;
    psum    = {1'b0, p1} + {1'b0, p2};
    dsum    = {1'b0, x2} + {1'b0, y2};
    lim     = $signed({2'b0, steer_limit});
    as16    = steer[15] ? -steer : steer;
    tsum    = 18'(steer) * 18'sd7 + 18'(filt) * 18'sd3;
    tn      = (tsum[17] ? 18'(-tsum) : 18'(tsum)) + 18'd5;
    tm      = rprod[35:21] <= 15'd40 ? 15'd0 : rprod[35:21];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_base  <= 12'd257;
      steer_limit <= 14'd4289;
      side_ratio  <= 16'd52429;
      reach_min   <= 15'd700;
      reach_max   <= 15'd1500;
      reach_gain  <= 16'd2867;
      speed_floor <= 15'd500;
      speed_cap   <= 15'd1500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WHEEL_BASE:  wheel_base  <= cfg_data[11:0];
        REG_STEER_LIMIT: steer_limit <= cfg_data[13:0];
        REG_SIDE_RATIO:  side_ratio  <= cfg_data;
        REG_REACH_MIN:   reach_min   <= cfg_data[14:0];
        REG_REACH_MAX:   reach_max   <= cfg_data[14:0];
        REG_REACH_GAIN:  reach_gain  <= cfg_data;
        REG_SPEED_FLOOR: speed_floor <= cfg_data[14:0];
        default:         speed_cap   <= cfg_data[14:0];
      endcase
    end
  end

  // sequencer: items, tick computation and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      live_bank  <= 1'b0;
      live_count <= '0;
      fill_count <= '0;
      age_cnt    <= AGE_SAT;
      filt       <= '0;
      own_speed  <= '0;
      m_tvalid   <= 1'b0;
      crd_start  <= 1'b0;
      div_start  <= 1'b0;
    end else begin
      crd_start <= (state == PREP) && (dsum > 32'd100);
      div_start <= (state == CORN) && (vm > 16'd10) && (steer_limit != '0);
      if (m_tvalid && m_tready && state != OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_acc) begin
            unique case (s_tuser)
              KIND_SPEED: own_speed <= $signed(s_tdata[15:0]);
              KIND_POINT: begin
                if (s_tlast) begin
                  live_bank  <= ~live_bank;
                  live_count <= (fill_count < CNT_W'(MAX_POINTS)) ? fill_count + 1'b1
                                                                   : fill_count;
                  fill_count <= '0;
                  age_cnt    <= '0;
                end else if (fill_count < CNT_W'(MAX_POINTS)) begin
                  fill_count <= fill_count + 1'b1;
                end
              end
              KIND_TICK: state <= AGE;
              default: ;
            endcase
          end
        end
        AGE: begin
          age_cnt <= age_n;
          gprod   <= reach_gain * spd;
          if (stale_n) begin
            r_drive <= '0;
            r_steer <= '0;
            r_aimx  <= '0;
            r_aimy  <= '0;
            r_stale <= 1'b1;
            state   <= OUT;
          end else begin
            state <= LA;
          end
        end
        LA: begin
          la    <= (l_c1 < reach_min) ? reach_min : l_c1;
          state <= LB;
        end
        LB: begin
          bprod <= la * side_ratio;
          state <= LC;
        end
        LC: begin
          a2    <= la * la;
          b2    <= bval * bval;
          state <= LD;
        end
        LD: begin
          lim2  <= a2 * b2;
          i     <= '0;
          state <= RD;
        end
        RD: state <= SQ;
        SQ: begin
          x2    <= sqx[30:0];
          y2    <= sqy[30:0];
          state <= MUL;
        end
        MUL: begin
          p1    <= x2 * b2;
          p2    <= y2 * a2;
          state <= CMP;
        end
        CMP: begin
          if (psum >= {2'b0, lim2}) begin
            idx   <= i;
            state <= PICK;
          end else if (i + 1'b1 >= live_count) begin
            idx   <= '0;
            state <= PICK;
          end else begin
            i     <= i + 1'b1;
            state <= RD;
          end
        end
        PICK: state <= FETCH;
        FETCH: begin
          ax    <= rx;
          ay    <= ry;
          pv    <= (rv > scap) ? scap : ((rv < -scap) ? -scap : rv);
          x2    <= sqx[30:0];
          y2    <= sqy[30:0];
          state <= PREP;
        end
        PREP: begin
          crd_num <= $signed({1'b0, wheel_base, 1'b0}) * ay;
          crd_den <= dsum;
          if (dsum > 32'd100) begin
            state <= CORD;
          end else begin
            steer <= '0;
            state <= CLAMP;
          end
        end
        CORD: begin
          if (crd_done) begin
            steer <= crd_angle;
            state <= CLAMP;
          end
        end
        CLAMP: begin
          steer <= (steer > lim) ? lim : ((steer < -lim) ? -lim : steer);
          neg   <= pv[15];
          vm    <= pv[15] ? 16'(-pv) : 16'(pv);
          state <= CORN;
        end
        CORN: begin
          dvd <= DIV_NW'(vm[14:0]) * DIV_NW'(as16[13:0]) * DIV_NW'(3);
          dvs <= DIV_DW'(steer_limit) * DIV_DW'(5);
          if (vm > 16'd10 && steer_limit != '0) begin
            state <= DIV;
          end else begin
            state <= FILT;
          end
        end
        DIV: begin
          if (div_done) begin
            vm    <= vm - 16'(div_q);
            state <= FILT;
          end
        end
        FILT: begin
          rprod <= tn * 18'd209716;
          tneg  <= tsum[17];
          state <= FIN;
        end
        FIN: begin
          filt    <= tneg ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
          r_steer <= tneg ? -$signed(tm) : $signed(tm);
          if (vm > 16'd10 && vm < {1'b0, speed_floor}) begin
            r_drive <= neg ? -$signed({1'b0, speed_floor}) : $signed({1'b0, speed_floor});
          end else if (vm <= 16'd10) begin
            r_drive <= '0;
          end else begin
            r_drive <= neg ? -$signed(vm) : $signed(vm);
          end
          r_aimx  <= ax;
          r_aimy  <= ay;
          r_stale <= 1'b0;
          state   <= OUT;
        end
        OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {1'b0, r_aimy, r_aimx, r_steer, r_drive};
            m_tuser  <= r_stale;
            m_tvalid <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// File: tb/tb_pure_pursuit_steering.sv
// self-checking testbench for the pure pursuit steering controller
module tb_pure_pursuit_steering;
  timeunit 1ns;
  timeprecision 1ps;
  import pps_pkg::*;

  typedef struct packed {
    logic signed [15:0] drive;
    logic signed [14:0] steer;
    logic signed [15:0] aim_x;
    logic signed [15:0] aim_y;
    logic               stale;
  } steer_cmd_t;

  localparam int IDLE_LIMIT = 6000;
  localparam int SETTLE     = 20;
  // kind code that the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  pure_pursuit_steering dut (.*);

  // golden copy of the controller state
  int   pt_x [0:2*MAX_POINTS-1];
  int   pt_y [0:2*MAX_POINTS-1];
  int   pt_v [0:2*MAX_POINTS-1];
  int   cur_bank, live_n, fill_n, age, own_spd;
  longint filt;
  longint wb, slim, sratio, rmin, rmax, rgain, sfloor, scap;

  steer_cmd_t cmd_q[$];
  int  mismatches;
  int  idle_cycles;
  int  burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int sext16(logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // angle of (den, num) in rad*8192 by 16 vectoring steps
  function automatic longint cordic_atan(longint num, longint den);
    longint cx, cy, cz, dx, dy;
    longint arcs [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
    cx = den; cy = num; cz = 0;
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; cz += arcs[i];
      end else begin
        cx -= dx; cy += dy; cz -= arcs[i];
      end
    end
    return (cz + 4) >>> 3;
  endfunction

  function automatic void golden_reset();
    cur_bank = 0; live_n = 0; fill_n = 0; age = 31; own_spd = 0; filt = 0;
    wb = 257; slim = 4289; sratio = 52429; rmin = 700; rmax = 1500;
    rgain = 2867; sfloor = 500; scap = 1500;
  endfunction

  function automatic void golden_config(logic [CFG_IW-1:0] idx, logic [15:0] val);
    case (idx)
      REG_WHEEL_BASE:  wb     = val & 16'hFFF;
      REG_STEER_LIMIT: slim   = val & 16'h3FFF;
      REG_SIDE_RATIO:  sratio = val;
      REG_REACH_MIN:   rmin   = val & 16'h7FFF;
      REG_REACH_MAX:   rmax   = val & 16'h7FFF;
      REG_REACH_GAIN:  rgain  = val;
      REG_SPEED_FLOOR: sfloor = val & 16'h7FFF;
      default:         scap   = val & 16'h7FFF;
    endcase
  endfunction

  // steering command for one control tick
  function automatic steer_cmd_t tick_command();
    steer_cmd_t c;
    longint la, lb, a2, b2, lim2, x, y, v, steer, vm, t, tm, r2;
    int idx, base, slot;
    bit neg;
    c = '0;
    if (age < 31) age++;
    if (age > STALE_TICKS || age == 31 || live_n == 0) begin
      c.stale = 1'b1;
      return c;
    end
    la = rmin + ((rgain * abs64(own_spd)) >> 12);
    if (la > rmax) la = rmax;
    if (la < rmin) la = rmin;
    lb = (la * sratio) >> 16;
    if (lb < 100) lb = 100;
    a2 = la * la; b2 = lb * lb; lim2 = a2 * b2;
    base = cur_bank * MAX_POINTS;
    idx = 0;
    for (int i = 0; i < live_n && i < MAX_POINTS; i++) begin
      x = pt_x[base+i]; y = pt_y[base+i];
      if (x * x * b2 + y * y * a2 >= lim2) begin
        idx = i;
        break;
      end
    end
    if (idx == 0 && live_n > 1) idx = live_n - 1;
    if (idx >= MAX_POINTS) idx = MAX_POINTS - 1;
    slot = base + idx;
    x = pt_x[slot]; y = pt_y[slot]; v = pt_v[slot];
    if (v > scap) v = scap;
    if (v < -scap) v = -scap;
    r2 = x * x + y * y;
    steer = (r2 > 100) ? cordic_atan(2 * wb * y, r2) : 0;
    if (steer > slim) steer = slim;
    if (steer < -slim) steer = -slim;
    neg = v < 0;
    vm = abs64(v);
    if (vm > 10 && slim > 0) vm -= (vm * abs64(steer) * 3) / (5 * slim);
    // low-pass with deadband
    t = 7 * steer + 3 * filt;
    tm = (abs64(t) + 5) / 10;
    if (tm <= 40) tm = 0;
    filt = (t < 0) ? -tm : tm;
    if (vm > 10 && vm < sfloor) vm = sfloor;
    else if (vm <= 10) vm = 0;
    c.drive = 16'(neg ? -vm : vm);
    c.steer = 15'(filt);
    c.aim_x = 16'(x);
    c.aim_y = 16'(y);
    return c;
  endfunction

  function automatic void golden_item(logic [1:0] kind, logic [63:0] data, logic last);
    int slot;
    case (kind)
      KIND_SPEED: own_spd = sext16(data[15:0]);
      KIND_POINT: begin
        if (fill_n < MAX_POINTS) begin
          slot = (cur_bank ^ 1) * MAX_POINTS + fill_n;
          pt_x[slot] = sext16(data[31:16]);
          pt_y[slot] = sext16(data[47:32]);
          pt_v[slot] = sext16(data[63:48]);
          fill_n++;
        end
        if (last) begin
          cur_bank ^= 1; live_n = fill_n; fill_n = 0; age = 0;
        end
      end
      KIND_TICK: cmd_q.push_back(tick_command());
      default: ;
    endcase
  endfunction

  // send one item, with bursts and gaps in between
  task automatic send_item(logic [1:0] kind, logic [63:0] data, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    golden_item(kind, data, last);
  endtask

  task automatic send_speed(int spd);
    send_item(KIND_SPEED, {48'($urandom), 16'(spd)}, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_point(int x, int y, int v, logic last);
    send_item(KIND_POINT, {16'(v), 16'(y), 16'(x), 16'($urandom)}, last);
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
  endtask

  // hold the sender until every command has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    golden_config(idx, 16'(val));
    @(posedge clk);
  endtask

  task automatic write_all(int w, int sl, int sr, int rn, int rx, int g, int f, int c);
    drain();
    write_reg(REG_WHEEL_BASE, w);
    write_reg(REG_STEER_LIMIT, sl);
    write_reg(REG_SIDE_RATIO, sr);
    write_reg(REG_REACH_MIN, rn);
    write_reg(REG_REACH_MAX, rx);
    write_reg(REG_REACH_GAIN, g);
    write_reg(REG_SPEED_FLOOR, f);
    write_reg(REG_SPEED_CAP, c);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 65535) - 32768;
      1:       return $urandom_range(0, 600) - 300;
      default: return $urandom_range(0, 6000) - 3000;
    endcase
  endfunction

  function automatic int rand_speed();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535) - 32768;
    return $urandom_range(0, 4000) - 2000;
  endfunction

  // stale and empty path, extremes of speed and coordinates, ignored kind
  task automatic test_directed();
    send_tick();
    send_speed(-32768);
    send_speed(32767);
    send_item(KIND_UNUSED, {$urandom, $urandom}, 1'b1);
    send_point(32767, -32768, 32767, 1'b0);
    send_point(-32768, 32767, -32768, 1'b0);
    send_point(3, -4, 20, 1'b1);
    send_tick();
    send_speed(0);
    send_tick();
    send_point(5, 5, -8, 1'b1);
    send_tick();
    send_point(0, 0, 300, 1'b0);
    send_point(1000, 200, -32768, 1'b0);
    send_point(2500, -1200, 900, 1'b1);
    send_tick();
    send_tick();
    send_speed(-1200);
    send_tick();
    // let the path age out
    repeat (11) send_tick();
  endtask

  // points past the bank size are dropped
  task automatic test_overflow();
    for (int i = 0; i < MAX_POINTS + 6; i++)
      send_point(i * 40 - 100, i * 7, 400 + i, i == MAX_POINTS + 5);
    send_tick();
    send_point(0, 0, 0, 1'b1);
    send_tick();
  endtask

  task automatic random_path(int maxlen);
    int n;
    n = (maxlen > 20 && $urandom_range(0, 9) == 0) ? $urandom_range(21, maxlen)
                                                    : $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      // stray updates in the middle of a fill
      if ($urandom_range(0, 9) == 0) send_speed(rand_speed());
      if ($urandom_range(0, 14) == 0) send_tick();
      send_point(rand_coord(), rand_coord(), rand_speed(), i == n - 1);
    end
  endtask

  task automatic test_random(int items, int maxlen);
    int sent;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0: begin
          send_item(KIND_UNUSED, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        end
        1, 2: begin
          send_speed(rand_speed());
          sent++;
        end
        3, 4, 5: begin
          random_path(maxlen);
          sent += 6;
        end
        default: begin
          repeat ($urandom_range(1, 4)) send_tick();
          sent += 2;
        end
      endcase
    end
  endtask

  task automatic test_config_sweep();
    write_all(4095, 12867, 65535, 32767, 32767, 65535, 32767, 32767);
    test_random(60, 20);
    write_all(1, 0, 0, 0, 0, 0, 0, 0);
    test_random(60, 20);
    write_all(100, 1, 0, 0, 32767, 65535, 0, 32767);
    test_random(60, 20);
    write_all(2000, 2000, 30000, 200, 8000, 4000, 9000, 20000);
    test_random(60, 20);
    write_all(257, 4289, 52429, 700, 1500, 2867, 500, 1500);
  endtask

  // receiver stalls in random modes, chosen anew from the free-running rx_cyc counter
  int rx_cyc;
  int rx_mode;
  always @(posedge clk) begin
    if (rst) begin
      rx_cyc  <= 0;
      rx_mode <= 0;
      m_tready <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (rx_cyc % 64 == 0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= (rx_cyc % 4 == 0);
        default: m_tready <= (rx_cyc % 32 > 22);
      endcase
    end
  end

  // compare each command with the oldest prediction
  always @(posedge clk) begin
    steer_cmd_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.drive = m_tdata[15:0];
      got.steer = m_tdata[30:16];
      got.aim_x = m_tdata[46:31];
      got.aim_y = m_tdata[62:47];
      got.stale = m_tuser;
      if (cmd_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected command: drive %0d steer %0d aim %0d,%0d stale %0b",
                   got.drive, got.steer, got.aim_x, got.aim_y, got.stale);
      end else begin
        want = cmd_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("command mismatch: exp drive %0d steer %0d aim %0d,%0d stale %0b",
                     want.drive, want.steer, want.aim_x, want.aim_y, want.stale);
            $display("                  got drive %0d steer %0d aim %0d,%0d stale %0b",
                     got.drive, got.steer, got.aim_x, got.aim_y, got.stale);
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    mismatches = 0;
    burst_left = 0;
    golden_reset();
    for (int i = 0; i < 2 * MAX_POINTS; i++) begin
      pt_x[i] = 0; pt_y[i] = 0; pt_v[i] = 0;
    end
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; s_tlast = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_overflow();
    test_config_sweep();
    test_random(150, 70);
    drain();
    test_random(200, 20);

    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
